// ===== rtl/tcf_pkg.sv =====
package tcf_pkg;

  localparam int ID_W    = 16;
  localparam int STAMP_W = 6;

  typedef enum logic [1:0] {
    MODE_ENQ     = 2'd0,
    MODE_DEQ_ANY = 2'd1,
    MODE_DEQ_C0  = 2'd2,
    MODE_DEQ_C1  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one queue slot: item id plus its arrival stamp
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

// ===== rtl/two_class_fifo_oldest_first.sv =====
// Two-class FIFO with oldest-first service.
// Input stream (s_axis_*): each transfer is one command. tuser carries the
// operation (enqueue, dequeue oldest of either class, of class 0, of class 1)
// and the item class; tdata carries the item id for an enqueue.
// Output stream (m_axis_*): exactly one result transfer per command, in order.
// tuser carries the status (ok, empty, full) and the class served; tdata the
// dequeued id, zero when nothing was dequeued.
// Every accepted enqueue gets a 6-bit arrival stamp; "either class" serves the
// head whose stamp is older, compared modulo 64.
// The result is registered and appears in the cycle after the command transfer.
// Throughput: one command per cycle while the receiver keeps up. Each class
// queue is a memory with one write and one registered read port; the read port
// always fetches the next head, so a command sees its head entry without waiting.
// Reset (rst, synchronous): both queues are emptied, the stamp counter
// returns to zero and the output register is dropped. No clearing pass.
// When the receiver stalls the result register holds; s_axis_tready falls
// only while a result is waiting and m_axis_tready is low.
module two_class_fifo_oldest_first #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] item_id
  input  logic [2:0]  s_axis_tuser,   // [1:0] mode, [2] item_class
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] out_id
  output logic [2:0]  m_axis_tuser    // [1:0] status, [2] out_class
);
  import tcf_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // per-class pointers and fill counts
  logic [AW-1:0]      head [2];
  logic [AW-1:0]      tail [2];
  logic [CW-1:0]      count [2];
  logic [AW-1:0]      head_next [2];
  logic [STAMP_W-1:0] arrival;

  // registered head entries, always valid for the current head
  entry_t             hd [2];

  logic               fire;
  mode_t              mode;
  logic               cls_in;
  logic [1:0]         push;
  logic [1:0]         pop;
  logic [1:0]         is_empty;
  logic [1:0]         is_full;
  logic               any_sel;
  logic [STAMP_W-1:0] stamp_diff;
  status_t            res_status;
  logic [ID_W-1:0]    res_id;
  logic               res_class;
  entry_t             wr_entry;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign mode          = mode_t'(s_axis_tuser[1:0]);
  assign cls_in        = s_axis_tuser[2];

  assign wr_entry.id    = s_axis_tdata;
  assign wr_entry.stamp = arrival;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      is_empty[c] = (count[c] == '0);
      is_full[c]  = (count[c] == CW'(QUEUE_DEPTH));
    end
    // top bit of (s0 - s1) mod 64 set: class 0 head is older
    stamp_diff = hd[0].stamp - hd[1].stamp;
    if (is_empty[1]) begin
      any_sel = 1'b0;
    end else if (is_empty[0]) begin
      any_sel = 1'b1;
    end else begin
      any_sel = !stamp_diff[STAMP_W-1];
    end
  end

  always_comb begin
    logic sel;
    sel        = 1'b0;
    push       = 2'b00;
    pop        = 2'b00;
    res_status = ST_OK;
    res_id     = '0;
    res_class  = 1'b0;
    case (mode)
      MODE_ENQ: begin
        if (is_full[cls_in]) begin
          res_status = ST_FULL;
        end else begin
          push[cls_in] = fire;
        end
      end
      MODE_DEQ_ANY, MODE_DEQ_C0, MODE_DEQ_C1: begin
        if (mode == MODE_DEQ_ANY) begin
          sel = any_sel;
        end else begin
          sel = (mode == MODE_DEQ_C1);
        end
        if (mode == MODE_DEQ_ANY && is_empty[0] && is_empty[1]) begin
          res_status = ST_EMPTY;
        end else if (is_empty[sel]) begin
          res_status = ST_EMPTY;
          res_class  = sel;
        end else begin
          pop[sel]  = fire;
          res_id    = hd[sel].id;
          res_class = sel;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      if (pop[c]) begin
        head_next[c] = (head[c] == AW'(QUEUE_DEPTH - 1)) ? '0 : head[c] + 1'b1;
      end else begin
        head_next[c] = head[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival <= '0;
      for (int c = 0; c < 2; c++) begin
        head[c]  <= '0;
        tail[c]  <= '0;
        count[c] <= '0;
      end
    end else begin
      if (push != 2'b00) begin
        arrival <= arrival + 1'b1;
      end
      for (int c = 0; c < 2; c++) begin
        head[c] <= head_next[c];
        if (push[c]) begin
          tail[c]  <= (tail[c] == AW'(QUEUE_DEPTH - 1)) ? '0 : tail[c] + 1'b1;
          count[c] <= count[c] + 1'b1;
        end else if (pop[c]) begin
          count[c] <= count[c] - 1'b1;
        end
      end
    end
  end

  // queue storage: one write port at the tail, one registered read port at the
  // next head; a write to that same slot is forwarded
  for (genvar c = 0; c < 2; c++) begin : g_queue
    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk) begin
      if (push[c]) begin
        mem[tail[c]] <= wr_entry;
      end
      if (push[c] && tail[c] == head_next[c]) begin
        hd[c] <= wr_entry;
      end else begin
        hd[c] <= mem[head_next[c]];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= res_id;
      m_axis_tuser <= {res_class, res_status};
    end
  end

endmodule

// ===== dv/two_class_fifo_checker.sv =====
module two_class_fifo_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] item_id
  input  logic [2:0]  s_axis_tuser,   // [1:0] mode, [2] item_class
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [15:0] out_id
  input  logic [2:0]  m_axis_tuser,   // [1:0] status, [2] out_class
  output int          mismatches,
  output int          outstanding
);
  import tcf_pkg::*;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] id;
    logic            cls;
  } reply_t;

  // mirror of both class queues
  entry_t             slots [2][QUEUE_DEPTH];
  int unsigned        head [2];
  int unsigned        fill [2];
  logic [STAMP_W-1:0] next_stamp;
  reply_t             awaited_replies [$];

  function automatic reply_t take_head(input logic c);
    reply_t r;
    r.cls = c;
    if (fill[c] == 0) begin
      r.status = ST_EMPTY;
      r.id     = '0;
    end else begin
      r.status = ST_OK;
      r.id     = slots[c][head[c]].id;
      head[c]  = (head[c] + 1) % QUEUE_DEPTH;
      fill[c]  = fill[c] - 1;
    end
    return r;
  endfunction

  function automatic reply_t serve_command(input mode_t op, input logic c,
                                           input logic [ID_W-1:0] item_id);
    reply_t             r;
    logic [STAMP_W-1:0] age_gap;
    r = '{status: ST_OK, id: '0, cls: 1'b0};
    case (op)
      MODE_ENQ: begin
        if (fill[c] >= QUEUE_DEPTH) begin
          r.status = ST_FULL;  // dropped, stamp does not advance
        end else begin
          slots[c][(head[c] + fill[c]) % QUEUE_DEPTH] = '{id: item_id, stamp: next_stamp};
          fill[c]    = fill[c] + 1;
          next_stamp = next_stamp + 1'b1;
        end
      end
      MODE_DEQ_C0: r = take_head(1'b0);
      MODE_DEQ_C1: r = take_head(1'b1);
      default: begin
        if (fill[0] == 0 && fill[1] == 0) begin
          r.status = ST_EMPTY;
        end else if (fill[0] == 0) begin
          r = take_head(1'b1);
        end else if (fill[1] == 0) begin
          r = take_head(1'b0);
        end else begin
          // class 0 wins only when its stamp is older modulo 64; ties go to class 1
          age_gap = slots[0][head[0]].stamp - slots[1][head[1]].stamp;
          r = take_head(age_gap[STAMP_W-1] ? 1'b0 : 1'b1);
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      head       = '{0, 0};
      fill       = '{0, 0};
      next_stamp = '0;
      awaited_replies.delete();
    end else begin
      // result side first: a result never leaves in the cycle of its command
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: result with nothing awaited: expected none, got status %0d id %h class %0d",
                   $time, m_axis_tuser[1:0], m_axis_tdata, m_axis_tuser[2]);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("status", 16'(want.status), 16'(m_axis_tuser[1:0]));
          check_field("out_id", want.id, m_axis_tdata);
          check_field("out_class", 16'(want.cls), 16'(m_axis_tuser[2]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_replies.push_back(serve_command(mode_t'(s_axis_tuser[1:0]),
                                                s_axis_tuser[2], s_axis_tdata));
    end
    outstanding = awaited_replies.size();
  end

endmodule

// ===== dv/tb_two_class_fifo_oldest_first.sv =====
module tb_two_class_fifo_oldest_first;
  import tcf_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 200000;

  // traffic mixes for the random part
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_CHURN} traffic_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;    // [15:0] item_id
  logic [2:0]  s_axis_tuser  = '0;    // [1:0] mode, [2] item_class
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [15:0] out_id
  logic [2:0]  m_axis_tuser;          // [1:0] status, [2] out_class
  int          mismatches;
  int          outstanding;
  int          cycles = 0;

  // receiver stall pattern state
  int unsigned ready_style = 0;
  int unsigned style_left  = 0;

  always #10 clk = ~clk;

  two_class_fifo_oldest_first #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (.*);

  two_class_fifo_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) scoreboard (.*);

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_two_class_fifo_oldest_first: errors");
      $finish;
    end
  end

  // receiver: switches between streaming, light, medium and heavy back-pressure
  always @(negedge clk) begin
    if (style_left == 0) begin
      ready_style = $urandom_range(0, 3);
      style_left  = $urandom_range(20, 120);
    end
    style_left--;
    case (ready_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= ($urandom_range(0, 1) == 0);
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // one command transfer; entered and left at a falling edge
  task automatic send_cmd(input mode_t op, input logic cls, input logic [15:0] item_id);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {cls, op};
    s_axis_tdata  <= item_id;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned seg_left;
    int unsigned enq_pct;
    int unsigned class1_pct;
    int unsigned roll;
    bit          hold_done;
    traffic_t    traffic;
    mode_t       op;
    logic        cls;

    sent      = 0;
    seg_left  = 0;
    hold_done = 1'b0;
    traffic   = MIX_EVEN;
    enq_pct   = 50;
    class1_pct = 50;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: empty queues on every dequeue flavor
    send_cmd(MODE_DEQ_ANY, 1'b1, 16'hFFFF);
    send_cmd(MODE_DEQ_C0, 1'b0, 16'h0000);
    send_cmd(MODE_DEQ_C1, 1'b1, 16'hFFFF);
    // class 1 arrives first, so "either" serves it, then falls to the only non-empty queue
    send_cmd(MODE_ENQ, 1'b1, 16'hFFFF);
    send_cmd(MODE_ENQ, 1'b0, 16'h0000);
    send_cmd(MODE_DEQ_ANY, 1'b0, 16'h0000);
    send_cmd(MODE_DEQ_ANY, 1'b1, 16'hFFFF);
    // fill class 0 to the brim, then one more that must be dropped
    for (int k = 0; k <= QUEUE_DEPTH; k++)
      send_cmd(MODE_ENQ, 1'b0, (k % 2) ? 16'hAAAA : 16'h5555);
    send_cmd(MODE_DEQ_ANY, 1'b1, 16'h1234);

    // random part: segments of one traffic mix, bursts separated by gaps
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 80);
          traffic  = traffic_t'($urandom_range(0, 3));
          case (traffic)
            MIX_FILL:  enq_pct = 80;
            MIX_DRAIN: enq_pct = 25;
            MIX_CHURN: enq_pct = 55;
            default:   enq_pct = 50;
          endcase
          case ($urandom_range(0, 2))
            0:       class1_pct = 10;
            1:       class1_pct = 90;
            default: class1_pct = 50;
          endcase
        end
        seg_left--;
        roll = $urandom_range(0, 99);
        cls  = ($urandom_range(0, 99) < class1_pct);
        if (traffic == MIX_CHURN) begin
          // class 1 churns while class 0 heads age, pushing stamps around the wrap
          if (roll < enq_pct) begin
            op  = MODE_ENQ;
            cls = 1'b1;
          end else begin
            op = MODE_DEQ_C1;
          end
        end else if (roll < enq_pct) begin
          op = MODE_ENQ;
        end else begin
          case ($urandom_range(0, 3))
            0:       op = MODE_DEQ_C0;
            1:       op = MODE_DEQ_C1;
            default: op = MODE_DEQ_ANY;
          endcase
        end
        send_cmd(op, cls, 16'($urandom));
        sent++;
      end
      if (!hold_done && sent >= RANDOM_ITEMS / 2) begin
        // hold off until the block has drained every result
        hold_done = 1'b1;
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
      end else if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_two_class_fifo_oldest_first: clean");
    end else begin
      $display("tb_two_class_fifo_oldest_first: errors");
    end
    $finish;
  end

endmodule
